// ----- design/pow2_block_allocator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Concurrent assertion helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POW2_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define POW2_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define PBA_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("allocator assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PBA_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("allocator assertion failed");
`else
`define PBA_ASSERT_IMP(label, ck, rn, ante, cons)
`define PBA_ASSERT_NXT(label, ck, rn, ante, cons)
`endif

`endif

// ----- design/pba_pkg.sv -----
// ----------------------------------------------------------------------------
// Allocator package
// Shared payload types, control structs and status codes.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int SIZE_BITS = 16;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_BAD      = 3'd4;

    localparam logic [SIZE_BITS-1:0] SIZE_MSB = {1'b1, {(SIZE_BITS-1){1'b0}}};

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic                 func;
        logic [SIZE_BITS-1:0] amount;
    } pba_req_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [SIZE_BITS-1:0] block_size;
        logic [SIZE_BITS-1:0] free_space;
        logic [SIZE_BITS-1:0] largest_block;
    } pba_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       ld_req;
        logic       ld_t;
        logic       halve_t;
        logic       commit_alloc;
        logic       ld_idx0;
        logic       inc_idx;
        logic       shift_wr;
        logic       commit_free;
        logic       ld_scan;
        logic       shift_scan;
        logic       ld_maxg;
        logic       finish;
        logic [2:0] status;
    } pba_cmd_t;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic func;
        logic free_zero;
        logic amt_zero;
        logic amt_too_big;
        logic t_half_ge;
        logic t_gt_free;
        logic cnt_zero;
        logic cnt_full;
        logic rd_match;
        logic idx_next_lt_cnt;
        logic scan_gt_free;
    } pba_stat_t;

endpackage

// ----- design/pba_ctrl.sv -----
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences decode, block rounding, table search and shift, and the
// largest-block scan for one request at a time.
// ----------------------------------------------------------------------------
module pba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  pba_pkg::pba_stat_t  stat,
    output pba_pkg::pba_cmd_t   cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_HALVE   = 4'd2;
    localparam logic [3:0] S_ACHK    = 4'd3;
    localparam logic [3:0] S_FLOOR   = 4'd4;
    localparam logic [3:0] S_FRD     = 4'd5;
    localparam logic [3:0] S_FCMP    = 4'd6;
    localparam logic [3:0] S_SRD     = 4'd7;
    localparam logic [3:0] S_SWR     = 4'd8;
    localparam logic [3:0] S_FCOMMIT = 4'd9;
    localparam logic [3:0] S_FINOK   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.ld_req = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.func == pba_pkg::FUNC_ALLOC)
                begin
                    priority if (stat.free_zero)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = pba_pkg::ST_NOSPACE;
                        state_next = S_IDLE;
                    end
                    else if (stat.amt_zero)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = pba_pkg::ST_BAD;
                        state_next = S_IDLE;
                    end
                    else if (stat.amt_too_big)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = pba_pkg::ST_NOSPACE;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.ld_t   = 1'b1;
                        state_next = S_HALVE;
                    end
                end
                else
                begin
                    if (stat.cnt_zero)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = pba_pkg::ST_EMPTY;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.ld_idx0 = 1'b1;
                        state_next  = S_FRD;
                    end
                end
            end
            S_HALVE:
            begin
                if (stat.t_half_ge)
                begin
                    cmd.halve_t = 1'b1;
                end
                else
                begin
                    state_next = S_ACHK;
                end
            end
            S_ACHK:
            begin
                priority if (stat.t_gt_free)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = pba_pkg::ST_NOSPACE;
                    state_next = S_IDLE;
                end
                else if (stat.cnt_full)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = pba_pkg::ST_BAD;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.commit_alloc = 1'b1;
                    cmd.ld_scan      = 1'b1;
                    state_next       = S_FLOOR;
                end
            end
            S_FLOOR:
            begin
                if (stat.scan_gt_free)
                begin
                    cmd.shift_scan = 1'b1;
                end
                else
                begin
                    cmd.ld_maxg = 1'b1;
                    state_next  = S_FINOK;
                end
            end
            S_FRD:
            begin
                state_next = S_FCMP;
            end
            S_FCMP:
            begin
                if (stat.rd_match)
                begin
                    cmd.inc_idx = 1'b1;
                    state_next  = stat.idx_next_lt_cnt ? S_SRD : S_FCOMMIT;
                end
                else if (stat.idx_next_lt_cnt)
                begin
                    cmd.inc_idx = 1'b1;
                    state_next  = S_FRD;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.status = pba_pkg::ST_NOTFOUND;
                    state_next = S_IDLE;
                end
            end
            S_SRD:
            begin
                state_next = S_SWR;
            end
            S_SWR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.inc_idx  = 1'b1;
                state_next   = stat.idx_next_lt_cnt ? S_SRD : S_FCOMMIT;
            end
            S_FCOMMIT:
            begin
                cmd.commit_free = 1'b1;
                cmd.ld_scan     = 1'b1;
                state_next      = S_FLOOR;
            end
            S_FINOK:
            begin
                cmd.finish = 1'b1;
                cmd.status = pba_pkg::ST_OK;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/pba_datapath.sv -----
// ----------------------------------------------------------------------------
// Allocator datapath
// Holds the size register, free space, largest block, the block table
// memory, the rounding and scan shifters and the result register.
// ----------------------------------------------------------------------------
module pba_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pba_pkg::SIZE_BITS-1:0]       cfg_wdata,
    input  pba_pkg::pba_req_t                   req,
    input  pba_pkg::pba_cmd_t                   cmd,
    output pba_pkg::pba_stat_t                  stat,
    output logic                                done,
    output pba_pkg::pba_rsp_t                   rsp
);

    localparam int SB    = pba_pkg::SIZE_BITS;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [SB-1:0] RESET_SIZE = SB'(1024);

    logic [SB-1:0]    total_reg;
    logic [SB-1:0]    free_reg;
    logic [SB-1:0]    maxg_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             func_reg;
    logic [SB-1:0]    amt_reg;
    logic [SB-1:0]    t_reg;
    logic [SB-1:0]    scan_reg;
    logic [SB-1:0]    rd_data_reg;
    logic             done_reg;
    pba_pkg::pba_rsp_t rsp_reg;

    logic [SB-1:0]    blk_mem [TABLE_DEPTH];

    logic [SB:0]      free_sum;
    logic [SB-1:0]    free_add_next;
    logic [CNT_W:0]   idx_plus1;
    logic [CNT_W-1:0] idx_minus1;

    assign free_sum      = {1'b0, free_reg} + {1'b0, amt_reg};
    assign free_add_next = free_sum[SB] ? {SB{1'b1}} : free_sum[SB-1:0];
    assign idx_plus1     = {1'b0, idx_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign idx_minus1    = idx_reg - {{(CNT_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        stat.func            = func_reg;
        stat.free_zero       = (free_reg == '0);
        stat.amt_zero        = (amt_reg == '0);
        stat.amt_too_big     = (amt_reg > maxg_reg) || (amt_reg > total_reg);
        stat.t_half_ge       = ((t_reg >> 1) >= amt_reg);
        stat.t_gt_free       = (t_reg > free_reg);
        stat.cnt_zero        = (count_reg == '0);
        stat.cnt_full        = (count_reg >= CNT_W'(TABLE_DEPTH));
        stat.rd_match        = (rd_data_reg == amt_reg);
        stat.idx_next_lt_cnt = (idx_plus1 < {1'b0, count_reg});
        stat.scan_gt_free    = (scan_reg > free_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= RESET_SIZE;
            free_reg  <= RESET_SIZE;
            maxg_reg  <= RESET_SIZE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
                free_reg  <= cfg_wdata;
                maxg_reg  <= cfg_wdata;
                count_reg <= '0;
            end
            else
            begin
                if (cmd.commit_alloc)
                begin
                    free_reg  <= free_reg - t_reg;
                    count_reg <= count_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                end
                else if (cmd.commit_free)
                begin
                    free_reg  <= free_add_next;
                    count_reg <= count_reg - {{(CNT_W-1){1'b0}}, 1'b1};
                end
                if (cmd.ld_maxg)
                begin
                    maxg_reg <= scan_reg;
                end
            end
        end
    end

    // Request latch, shifters, index and result; no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_req)
        begin
            func_reg <= req.func;
            amt_reg  <= req.amount;
        end
        if (cmd.ld_t)
        begin
            t_reg <= total_reg;
        end
        else if (cmd.halve_t)
        begin
            t_reg <= t_reg >> 1;
        end
        if (cmd.ld_scan)
        begin
            scan_reg <= pba_pkg::SIZE_MSB;
        end
        else if (cmd.shift_scan)
        begin
            scan_reg <= scan_reg >> 1;
        end
        if (cmd.ld_idx0)
        begin
            idx_reg <= '0;
        end
        else if (cmd.inc_idx)
        begin
            idx_reg <= idx_plus1[CNT_W-1:0];
        end
        if (cmd.finish)
        begin
            rsp_reg.status        <= cmd.status;
            rsp_reg.free_space    <= free_reg;
            rsp_reg.largest_block <= maxg_reg;
            if (cmd.status != pba_pkg::ST_OK)
            begin
                rsp_reg.block_size <= '0;
            end
            else if (func_reg == pba_pkg::FUNC_FREE)
            begin
                rsp_reg.block_size <= amt_reg;
            end
            else
            begin
                rsp_reg.block_size <= t_reg;
            end
        end
    end

    // Block table: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.commit_alloc)
        begin
            blk_mem[count_reg[IDX_W-1:0]] <= t_reg;
        end
        else if (cmd.shift_wr)
        begin
            blk_mem[idx_minus1[IDX_W-1:0]] <= rd_data_reg;
        end
        rd_data_reg <= blk_mem[idx_reg[IDX_W-1:0]];
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- design/pow2_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Power-of-two block allocator
// Size-only buddy-style allocator: grants and releases blocks of
// total_size / 2^z and tracks free space and the largest grantable block.
// ----------------------------------------------------------------------------
// Usage:
// A request transfer happens on a rising edge where start is high and busy is
// low; req carries func (0 allocate, 1 free) and amount. Exactly one result
// per request appears on rsp for one cycle with done high. The receiver cannot
// stall, so the result must be taken in that cycle.
// A request rejected at decode is answered straight from there. Otherwise an
// allocate rounds total_size down to the block by up to 15 halvings, and a
// granted allocate ends with the largest-block scan of up to 16 steps. A free
// reads the table entry by entry until it finds its block, then shifts each
// later entry down one place, since the block table is a memory with one
// registered read port; entries examined plus entries shifted come to at most
// TABLE_DEPTH. A free that finds its block also ends with the scan. A new
// request may be transferred in the done cycle.
// Reset restores total_size to 1024, empties the table and sets free space
// and largest block to 1024. A cfg_we write, issued while idle, loads
// total_size and restarts the allocator the same way.
// ----------------------------------------------------------------------------
`include "pow2_block_allocator_unit_defines.svh"

module pow2_block_allocator_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pba_pkg::pba_req_t             req,
    output logic                          done,
    output pba_pkg::pba_rsp_t             rsp,
    input  logic                          cfg_we,
    input  logic [pba_pkg::SIZE_BITS-1:0] cfg_wdata
);

    pba_pkg::pba_cmd_t  cmd;
    pba_pkg::pba_stat_t stat;

    // The controller walks one request at a time through its steps.
    pba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // The datapath owns all allocator state and the result register.
    pba_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wdata (cfg_wdata),
        .cfg_we    (cfg_we),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .rsp       (rsp)
    );

    // A result is only presented once the controller has gone back to idle.
    `PBA_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    // An accepted request always occupies the controller in the next cycle.
    `PBA_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
    // Failed requests grant or release nothing.
    `PBA_ASSERT_IMP(a_err_zero, clk, rst_n, done && (rsp.status != pba_pkg::ST_OK),
        rsp.block_size == '0)
    // After a successful request the largest block is a power of two within free space.
    `PBA_ASSERT_IMP(a_ok_largest, clk, rst_n, done && (rsp.status == pba_pkg::ST_OK),
        $onehot0(rsp.largest_block) && (rsp.largest_block <= rsp.free_space))

endmodule

// ----- tb/tb_pow2_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Power-of-two block allocator testbench
// Drives allocate and free requests through the start/busy handshake, predicts
// every response with an independent model of the allocator and checks each
// done pulse against the oldest prediction. Several total_size settings are
// exercised, including both extremes.
// ----------------------------------------------------------------------------
module tb_pow2_block_allocator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int SIZE_BITS   = pba_pkg::SIZE_BITS;

    // Clock and reset. All inputs hold known values from time zero.
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    pba_pkg::pba_req_t    req       = '0;
    logic                 done;
    pba_pkg::pba_rsp_t    rsp;
    logic                 cfg_we    = 1'b0;
    logic [SIZE_BITS-1:0] cfg_wdata = '0;

    // Requests waiting to be driven, and responses predicted for requests that
    // have already been transferred into the block.
    pba_pkg::pba_req_t pending_reqs[$];
    pba_pkg::pba_rsp_t expected_rsps[$];

    // Sender idling: percent chance of starting a burst, and cycles left in it.
    int unsigned idle_pct = 0;
    int unsigned gap_left = 0;
    int unsigned mismatch_count = 0;

    // Shadow copy of the allocator state.
    logic [SIZE_BITS-1:0] mdl_total;
    logic [SIZE_BITS-1:0] mdl_free;
    logic [SIZE_BITS-1:0] mdl_largest;
    logic [SIZE_BITS-1:0] mdl_blocks [TABLE_DEPTH];
    int unsigned          mdl_count;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    pow2_block_allocator_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Largest power of two that does not exceed v, or zero when v is zero.
    function automatic logic [SIZE_BITS-1:0] pow2_at_most(logic [SIZE_BITS-1:0] v);
        logic [SIZE_BITS-1:0] p;
        int                   b;
        p = '0;
        for (b = 0; b < SIZE_BITS; b++)
        begin
            if (v[b])
            begin
                p    = '0;
                p[b] = 1'b1;
            end
        end
        return p;
    endfunction

    // Loading total_size restarts everything: all memory free, table empty.
    function automatic void restart_allocator(logic [SIZE_BITS-1:0] total);
        mdl_total   = total;
        mdl_free    = total;
        mdl_largest = total;
        mdl_count   = 0;
    endfunction

    // Applies one request to the shadow state and returns the response the
    // block must give for it.
    function automatic pba_pkg::pba_rsp_t apply_request(pba_pkg::pba_req_t r);
        pba_pkg::pba_rsp_t    res;
        logic [2:0]           st;
        logic [SIZE_BITS-1:0] blk;
        logic [SIZE_BITS:0]   sum;
        int                   hit;
        int                   j;
        st  = pba_pkg::ST_OK;
        blk = '0;
        if (r.func == pba_pkg::FUNC_ALLOC)
        begin
            blk = mdl_total;
            if (mdl_free == '0)
                st = pba_pkg::ST_NOSPACE;
            else if (r.amount == '0)
                st = pba_pkg::ST_BAD;
            else if (r.amount > mdl_largest || r.amount > mdl_total)
                st = pba_pkg::ST_NOSPACE;
            else
            begin
                // Halve the whole memory until one more halving would undershoot.
                while ((blk >> 1) >= r.amount)
                    blk = blk >> 1;
                if (blk > mdl_free)
                    st = pba_pkg::ST_NOSPACE;
                else if (mdl_count >= TABLE_DEPTH)
                    st = pba_pkg::ST_BAD;
                else
                begin
                    mdl_free              = mdl_free - blk;
                    mdl_blocks[mdl_count] = blk;
                    mdl_count++;
                    mdl_largest           = pow2_at_most(mdl_free);
                end
            end
        end
        else
        begin
            hit = -1;
            if (mdl_count == 0)
                st = pba_pkg::ST_EMPTY;
            else
            begin
                for (j = 0; j < mdl_count; j++)
                begin
                    if (hit < 0 && mdl_blocks[j] == r.amount)
                        hit = j;
                end
                if (hit < 0)
                    st = pba_pkg::ST_NOTFOUND;
                else
                begin
                    for (j = hit; j + 1 < mdl_count; j++)
                        mdl_blocks[j] = mdl_blocks[j + 1];
                    mdl_count--;
                    sum         = {1'b0, mdl_free} + {1'b0, r.amount};
                    mdl_free    = sum[SIZE_BITS] ? '1 : sum[SIZE_BITS-1:0];
                    mdl_largest = pow2_at_most(mdl_free);
                    blk         = r.amount;
                end
            end
        end
        if (st != pba_pkg::ST_OK)
            blk = '0;
        res.status        = st;
        res.block_size    = blk;
        res.free_space    = mdl_free;
        res.largest_block = mdl_largest;
        return res;
    endfunction

    // Driver. A request transfer happens on an edge with start high and busy
    // low; the prediction is made right there, so the expected responses line
    // up with the order of transfers. Between requests the sender may idle in
    // bursts. start and req each get a single nonblocking update per edge, so
    // back-to-back transfers keep start high without a glitch.
    always @(posedge clk)
    begin : drive_proc
        logic              nxt_start;
        pba_pkg::pba_req_t nxt_req;
        nxt_start = start;
        nxt_req   = req;
        if (!rst_n)
        begin
            nxt_start = 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_rsps.push_back(apply_request(req));
                nxt_start = 1'b0;
            end
            if (!nxt_start && pending_reqs.size() != 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if ($urandom_range(0, 99) < idle_pct)
                    gap_left = $urandom_range(0, 17);
                else
                begin
                    nxt_req   = pending_reqs.pop_front();
                    nxt_start = 1'b1;
                end
            end
        end
        start <= nxt_start;
        req   <= nxt_req;
    end

    // Monitor. The block cannot be stalled, so every done cycle is a response
    // transfer and is checked field by field against the oldest prediction.
    always @(posedge clk)
    begin : check_proc
        pba_pkg::pba_rsp_t want;
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: response with nothing outstanding:", $realtime,
                             " st=%0d blk=%0d free=%0d lg=%0d",
                             rsp.status, rsp.block_size, rsp.free_space,
                             rsp.largest_block);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.status !== want.status || rsp.block_size !== want.block_size ||
                    rsp.free_space !== want.free_space ||
                    rsp.largest_block !== want.largest_block)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: response mismatch", $realtime);
                        $display("    expected st=%0d blk=%0d free=%0d lg=%0d",
                                 want.status, want.block_size, want.free_space,
                                 want.largest_block);
                        $display("    actual   st=%0d blk=%0d free=%0d lg=%0d",
                                 rsp.status, rsp.block_size, rsp.free_space,
                                 rsp.largest_block);
                    end
                end
            end
        end
    end

    task automatic queue_req(logic f, logic [SIZE_BITS-1:0] a);
        pba_pkg::pba_req_t r;
        r.func   = f;
        r.amount = a;
        pending_reqs.push_back(r);
    endtask

    // Waits until every queued request has been transferred and every response
    // has come back, then lets a few more cycles pass. Sampling on the falling
    // edge keeps the check clear of the updates made on the rising edge.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    // Writes total_size while the block is idle; the shadow state restarts too.
    task automatic write_total(logic [SIZE_BITS-1:0] v);
        wait_quiet();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        restart_allocator(v);
        @(negedge clk);
    endtask

    // Random requests for the current total_size. Most of them use block sizes
    // that the current setting can actually produce, so frees often find their
    // block and the table fills and drains; a few are arbitrary 16-bit noise.
    task automatic queue_random(int unsigned n);
        int unsigned          i;
        int unsigned          roll;
        int unsigned          z;
        logic [SIZE_BITS-1:0] blk;
        for (i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            z    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 6);
            blk  = mdl_total >> z;
            if (roll < 55)
            begin
                // Any request in (blk/2, blk] rounds up to blk.
                if (blk > 1 && $urandom_range(0, 1) == 1)
                    queue_req(pba_pkg::FUNC_ALLOC,
                              SIZE_BITS'($urandom_range(blk / 2 + 1, blk)));
                else
                    queue_req(pba_pkg::FUNC_ALLOC, blk);
            end
            else if (roll < 93)
                queue_req(pba_pkg::FUNC_FREE, blk);
            else
                queue_req(1'($urandom_range(0, 1)), SIZE_BITS'($urandom_range(0, 65535)));
        end
    endtask

    task automatic run_phase(logic [SIZE_BITS-1:0] total, int unsigned n, int unsigned pct);
        write_total(total);
        idle_pct = pct;
        queue_random(n);
    endtask

    initial
    begin : stimulus_proc
        int unsigned i;
        restart_allocator(16'd1024);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed checks at the reset size of 1024.
        idle_pct = 25;
        queue_req(pba_pkg::FUNC_FREE, 16'd0);        // free while nothing is allocated
        queue_req(pba_pkg::FUNC_ALLOC, 16'd0);       // zero-sized request
        queue_req(pba_pkg::FUNC_ALLOC, 16'd1025);    // bigger than the largest block
        queue_req(pba_pkg::FUNC_ALLOC, 16'd1024);    // whole memory, leaves nothing free
        queue_req(pba_pkg::FUNC_ALLOC, 16'd1);       // nothing free at all
        queue_req(pba_pkg::FUNC_FREE, 16'd512);      // size not in the table
        queue_req(pba_pkg::FUNC_FREE, 16'd1024);     // gives the whole memory back
        queue_req(pba_pkg::FUNC_ALLOC, 16'd300);     // rounds up to 512

        // With a size that is not a power of two, a request can pass the
        // largest-block test yet round up past the free space: after taking
        // one unit, 501 rounds to the full 1000 while only 999 is free.
        write_total(16'd1000);
        queue_req(pba_pkg::FUNC_ALLOC, 16'd1);
        queue_req(pba_pkg::FUNC_ALLOC, 16'd501);

        // Seventeen one-unit blocks in 17 units of memory: the last request
        // finds a unit free but the table already full.
        write_total(16'd17);
        for (i = 0; i < 17; i++)
            queue_req(pba_pkg::FUNC_ALLOC, 16'd1);

        // Random phases over several sizes, both extremes among them.
        run_phase(16'd1024, 220, 30);
        run_phase(16'd1, 120, 30);
        run_phase(16'hFFFF, 220, 0);
        run_phase(16'd1000, 200, 40);
        run_phase(SIZE_BITS'($urandom_range(1, 65535)), 200, 30);

        // The sender holds off halfway until every response has come back.
        run_phase(16'd32768, 110, 20);
        wait_quiet();
        queue_random(110);

        run_phase(SIZE_BITS'($urandom_range(1, 65535)), 200, 30);

        // Last stretch at full rate with no sender gaps.
        run_phase(16'd1024, 230, 0);

        wait_quiet();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && expected_rsps.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: a hung handshake ends the run.
    initial
    begin : watchdog_proc
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/pba_pkg.sv
design/pba_ctrl.sv
design/pba_datapath.sv
design/pow2_block_allocator_unit.sv
tb/tb_pow2_block_allocator_unit.sv
